FILE: rtl/ccnc_pkg.sv
// Shared types, constants and helpers for the costate-to-control norm clamp.
// No dependencies; every other file in rtl imports it.
package ccnc_pkg;

  localparam int LATENCY = 102;
  localparam int DIV_STEPS = 32;
  localparam int SQRT_STEPS = 32;
  localparam int AXES = 3;

  localparam logic [1:0] REG_ACCEL_LIMIT = 2'd0;
  localparam logic [1:0] REG_NORM_LIMIT  = 2'd1;

  localparam logic [31:0] ACCEL_LIMIT_RST = 32'd19661;
  localparam logic [31:0] NORM_LIMIT_RST  = 32'd655360;

  typedef struct packed {
    logic signed [31:0] costate_vx;
    logic signed [31:0] costate_vy;
    logic signed [31:0] costate_vz;
  } costate_t;

  typedef struct packed {
    logic signed [31:0] control_x;
    logic signed [31:0] control_y;
    logic signed [31:0] control_z;
    logic               clipped;
  } control_t;

  // One restoring-division step: partial remainder, dividend bits still to
  // shift in, quotient so far, divisor.
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
    logic [31:0] den;
  } div_cell_t;

  // One square-root digit step.
  typedef struct packed {
    logic [33:0] rem;
    logic [63:0] rad;
    logic [31:0] root;
  } sqrt_cell_t;

  // Clamp a magnitude to what a signed 32-bit word can hold with that sign.
  function automatic logic [31:0] clamp_mag(input logic [32:0] mag, input logic neg);
    logic [31:0] res;
    if (neg) begin
      res = (mag >= 33'h0_8000_0000) ? 32'h8000_0000 : mag[31:0];
    end else begin
      res = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] apply_sign(input logic [31:0] mag, input logic neg);
    return neg ? (32'd0 - mag) : mag;
  endfunction

endpackage

FILE: rtl/ccnc_div_cell.sv
// One registered restoring-division step (one quotient bit).
// Depends on ccnc_pkg.
module ccnc_div_cell (
  input  logic                clk,
  input  ccnc_pkg::div_cell_t cur,
  output ccnc_pkg::div_cell_t nxt
);
  import ccnc_pkg::*;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        take;
  div_cell_t   nxt_next;

  always_comb begin
    trial = {cur.rem, cur.low[31]};
    diff  = trial - {1'b0, cur.den};
    take  = (trial >= {1'b0, cur.den});
    nxt_next.rem = take ? diff[31:0] : trial[31:0];
    nxt_next.low = {cur.low[30:0], 1'b0};
    nxt_next.quo = {cur.quo[30:0], take};
    nxt_next.den = cur.den;
  end

  always_ff @(posedge clk) begin
    nxt <= nxt_next;
  end

endmodule

FILE: rtl/ccnc_sqrt_cell.sv
// One registered integer square-root step (one root bit, two radicand bits).
// Depends on ccnc_pkg.
module ccnc_sqrt_cell (
  input  logic                 clk,
  input  ccnc_pkg::sqrt_cell_t cur,
  output ccnc_pkg::sqrt_cell_t nxt
);
  import ccnc_pkg::*;

  logic [35:0] part;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        take;
  sqrt_cell_t  nxt_next;

  always_comb begin
    part  = {cur.rem, cur.rad[63:62]};
    trial = {2'b00, cur.root, 2'b01};
    diff  = part - trial;
    take  = (part >= trial);
    nxt_next.rem  = take ? diff[33:0] : part[33:0];
    nxt_next.rad  = {cur.rad[61:0], 2'b00};
    nxt_next.root = {cur.root[30:0], take};
  end

  always_ff @(posedge clk) begin
    nxt <= nxt_next;
  end

endmodule

FILE: rtl/costate_control_norm_clamp.sv
// Costate-to-control with Euclidean norm clamp on three axes, signed Q16.16.
// One word per cycle enters (busy stays low) and each result appears on
// result with done high for one cycle. The pipeline is three rows of
// one-bit step cells: 32 for the per-axis divide by accel_limit, 32 for
// the square root of the squared norm and 32 for the rescale divide, plus
// six pipeline registers.
// Write configuration only while no word is in flight.
module costate_control_norm_clamp (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ccnc_pkg::costate_t costate,
  output logic               done,
  output ccnc_pkg::control_t result,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import ccnc_pkg::*;

  typedef struct packed {
    logic [AXES-1:0] neg;
    logic [AXES-1:0] ovf;
    logic [AXES-1:0] pz;
  } sb1_t;

  typedef struct packed {
    logic [AXES-1:0][31:0] mag;
    logic [AXES-1:0]       neg;
    logic                  clip;
  } sb2_t;

  logic [31:0] accel_limit;
  logic [31:0] control_norm_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_limit        <= ACCEL_LIMIT_RST;
      control_norm_limit <= NORM_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACCEL_LIMIT: accel_limit        <= cfg_data;
        REG_NORM_LIMIT:  control_norm_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------- input stage
  logic            accept;
  logic [31:0]     p_in [AXES];
  logic [31:0]     pm [AXES];
  div_cell_t       d1 [AXES][DIV_STEPS+1];
  sb1_t            sb1 [DIV_STEPS+1];
  sb1_t            sb1_next;
  logic [DIV_STEPS:0] v1;

  assign accept = start && !busy;
  assign p_in[0] = costate.costate_vx;
  assign p_in[1] = costate.costate_vy;
  assign p_in[2] = costate.costate_vz;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      pm[i] = p_in[i][31] ? (32'd0 - p_in[i]) : p_in[i];
      sb1_next.neg[i] = !p_in[i][31] && (p_in[i] != 32'd0);
      sb1_next.pz[i]  = (p_in[i] == 32'd0);
      sb1_next.ovf[i] = (p_in[i] != 32'd0) &&
                        ({16'd0, pm[i]} >= {accel_limit, 16'd0});
    end
  end

  always_ff @(posedge clk) begin
    sb1[0] <= sb1_next;
    for (int k = 0; k < DIV_STEPS; k++) begin
      sb1[k+1] <= sb1[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= '0;
    end else begin
      v1 <= {v1[DIV_STEPS-1:0], accept};
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_div1
    always_ff @(posedge clk) begin
      d1[a][0].rem <= {16'd0, pm[a][31:16]};
      d1[a][0].low <= {pm[a][15:0], 16'd0};
      d1[a][0].quo <= 32'd0;
      d1[a][0].den <= accel_limit;
    end
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
      ccnc_div_cell u_cell (.clk(clk), .cur(d1[a][k]), .nxt(d1[a][k+1]));
    end
  end

  // ---------------- saturate, square, sum
  logic [AXES-1:0][31:0] um;
  logic [AXES-1:0]       uneg;
  logic [AXES-1:0][63:0] sq;
  logic [AXES-1:0][31:0] sq_m;
  logic [AXES-1:0]       sq_neg;
  logic [63:0]           usq;
  logic [63:0]           sum;
  logic [63:0]           sum_usq;
  logic [AXES-1:0][31:0] sum_m;
  logic [AXES-1:0]       sum_neg;
  logic                  v_u, v_sq, v_sum;
  logic [32:0]           qmag [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      qmag[i] = sb1[DIV_STEPS].ovf[i] ? 33'h1_0000_0000 :
                sb1[DIV_STEPS].pz[i]  ? 33'd0 : {1'b0, d1[i][DIV_STEPS].quo};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < AXES; i++) begin
      um[i]   <= clamp_mag(qmag[i], sb1[DIV_STEPS].neg[i]);
      uneg[i] <= sb1[DIV_STEPS].neg[i];
      sq[i]   <= {32'd0, um[i]} * {32'd0, um[i]};
    end
    sq_m    <= um;
    sq_neg  <= uneg;
    usq     <= {32'd0, control_norm_limit} * {32'd0, control_norm_limit};
    sum     <= sq[0] + sq[1] + sq[2];
    sum_usq <= usq;
    sum_m   <= sq_m;
    sum_neg <= sq_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_u   <= 1'b0;
      v_sq  <= 1'b0;
      v_sum <= 1'b0;
    end else begin
      v_u   <= v1[DIV_STEPS];
      v_sq  <= v_u;
      v_sum <= v_sq;
    end
  end

  // ---------------- square root row
  sqrt_cell_t         sr [SQRT_STEPS+1];
  sb2_t               sb2 [SQRT_STEPS+1];
  logic [SQRT_STEPS:0] v2;

  always_comb begin
    sr[0].rem  = '0;
    sr[0].rad  = sum;
    sr[0].root = '0;
    sb2[0].mag  = sum_m;
    sb2[0].neg  = sum_neg;
    sb2[0].clip = (sum > sum_usq);
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    ccnc_sqrt_cell u_cell (.clk(clk), .cur(sr[k]), .nxt(sr[k+1]));
    always_ff @(posedge clk) begin
      sb2[k+1] <= sb2[k];
    end
  end

  assign v2[0] = v_sum;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2[SQRT_STEPS:1] <= '0;
    end else begin
      v2[SQRT_STEPS:1] <= v2[SQRT_STEPS-1:0];
    end
  end

  // ---------------- rescale: |u| * u_max / norm
  logic [31:0]  norm;
  div_cell_t    d2 [AXES][DIV_STEPS+1];
  sb2_t         sb3 [DIV_STEPS+1];
  logic [DIV_STEPS:0] v3;
  logic [63:0]  prod [AXES];

  assign norm = (sr[SQRT_STEPS].root == 32'd0) ? 32'd1 : sr[SQRT_STEPS].root;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      prod[i] = {32'd0, sb2[SQRT_STEPS].mag[i]} * {32'd0, control_norm_limit};
    end
  end

  always_ff @(posedge clk) begin
    sb3[0] <= sb2[SQRT_STEPS];
    for (int k = 0; k < DIV_STEPS; k++) begin
      sb3[k+1] <= sb3[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= '0;
    end else begin
      v3 <= {v3[DIV_STEPS-1:0], v2[SQRT_STEPS]};
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_div2
    always_ff @(posedge clk) begin
      d2[a][0].rem <= prod[a][63:32];
      d2[a][0].low <= prod[a][31:0];
      d2[a][0].quo <= 32'd0;
      d2[a][0].den <= norm;
    end
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
      ccnc_div_cell u_cell (.clk(clk), .cur(d2[a][k]), .nxt(d2[a][k+1]));
    end
  end

  // ---------------- output word
  logic [31:0] fmag [AXES];
  logic [31:0] fval [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      fmag[i] = sb3[DIV_STEPS].clip ?
                clamp_mag({1'b0, d2[i][DIV_STEPS].quo}, sb3[DIV_STEPS].neg[i]) :
                sb3[DIV_STEPS].mag[i];
      fval[i] = apply_sign(fmag[i], sb3[DIV_STEPS].neg[i]);
    end
  end

  always_ff @(posedge clk) begin
    result.control_x <= fval[0];
    result.control_y <= fval[1];
    result.control_z <= fval[2];
    result.clipped   <= sb3[DIV_STEPS].clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3[DIV_STEPS];
    end
  end

endmodule

FILE: rtl/ccnc_checker.sv
// Port-level checks for costate_control_norm_clamp, bound to the top level.
// Depends on ccnc_pkg.
module ccnc_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input ccnc_pkg::control_t result
);
  import ccnc_pkg::*;

  // every result word traces back to a start exactly one latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, LATENCY))
    else $error("done without a start one pipeline latency earlier");

  // every started word comes back
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    $past(start && !busy && !rst, LATENCY) |-> done)
    else $error("started word did not come back after the pipeline latency");

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("done right after reset");

  a_clip_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown(result.clipped))
    else $error("clipped flag unknown on a result word");

endmodule

bind costate_control_norm_clamp ccnc_checker u_ccnc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);
